[sv/nre_pkg.sv]
package nre_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [15:0] CAP_RESET  = 16'hFFFF;
    localparam logic [11:0] WIDE_CAP   = 12'h0FFF;
    localparam logic [11:0] NARROW_CAP = 12'h000F;
    localparam logic [3:0]  GRAY_BLACK = 4'h0;
    localparam logic [3:0]  GRAY_WHITE = 4'hF;

    // One code of a finished run
    typedef struct packed {
        logic        vld;
        logic [3:0]  gray;
        logic [11:0] cnt;
    } t_code;

    // Everything one input beat produces: up to three codes, in order
    typedef struct packed {
        t_code [2:0] codes;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic        open;
        logic [3:0]  gray;
        logic [11:0] cnt;
    } t_run;

    typedef struct packed {
        t_run  run;
        t_code code;
    } t_step;

    function automatic logic is_wide(input logic [3:0] g);
        return (g == GRAY_BLACK) || (g == GRAY_WHITE);
    endfunction

    // Fold one gray nibble into the open run
    function automatic t_step run_step(input t_run s, input logic [3:0] g);
        t_step       r;
        logic [11:0] cap;
        cap    = is_wide(g) ? WIDE_CAP : NARROW_CAP;
        r.run  = s;
        r.code = '0;
        if (s.open && (g == s.gray)) begin
            if (s.cnt >= cap) begin
                r.code.vld  = 1'b1;
                r.code.gray = g;
                r.code.cnt  = cap;
                r.run.cnt   = 12'd1;
            end else begin
                r.run.cnt = s.cnt + 12'd1;
            end
        end else begin
            r.code.vld  = s.open;
            r.code.gray = s.gray;
            r.code.cnt  = s.cnt;
            r.run.open  = 1'b1;
            r.run.gray  = g;
            r.run.cnt   = 12'd1;
        end
        return r;
    endfunction

endpackage

[sv/nre_front.sv]
module nre_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic            i_q_ready,
    output logic            o_push,
    output nre_pkg::t_entry o_entry
);
    import nre_pkg::*;

    t_run  r_run;
    t_run  n_run;
    t_step w_hi;
    t_step w_lo;
    logic  w_accept;

    always_comb begin
        w_hi = run_step(r_run, i_data_byte[7:4]);
        w_lo = run_step(w_hi.run, i_data_byte[3:0]);
        o_entry.codes[0] = w_hi.code;
        o_entry.codes[1] = w_lo.code;
        o_entry.last     = i_last_byte;
        o_entry.codes[2] = '0;
        n_run            = w_lo.run;
        if (i_last_byte) begin
            // flush the open run and close it
            o_entry.codes[2].vld  = w_lo.run.open;
            o_entry.codes[2].gray = w_lo.run.gray;
            o_entry.codes[2].cnt  = w_lo.run.cnt;
            n_run.open = 1'b0;
            n_run.cnt  = '0;
        end
    end

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && i_q_ready;
    // skip beats that finish no run
    assign o_push     = w_accept && (o_entry.codes[0].vld || o_entry.codes[1].vld
                                     || o_entry.codes[2].vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (w_accept) begin
            r_run <= n_run;
        end
    end

endmodule

[sv/nre_fifo.sv]
module nre_fifo #(
    parameter int unsigned Depth = nre_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nre_pkg::t_entry i_entry,
    output logic            o_rdy,
    input  logic            i_pop,
    output logic            o_vld,
    output nre_pkg::t_entry o_entry
);
    import nre_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CW = $clog2(Depth + 1);

    t_entry         r_mem [Depth];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_rdy   = (r_cnt != CW'(Depth));
    assign o_vld   = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign w_wr    = i_push && o_rdy;
    assign w_rd    = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[sv/nre_back.sv]
module nre_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata,
    input  logic            i_q_valid,
    input  nre_pkg::t_entry i_q_entry,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_code_byte,
    output logic            o_item_last,
    output logic            o_stream_end,
    output logic [15:0]     o_bytes_written
);
    import nre_pkg::*;

    logic        r_busy;
    t_entry      r_ent;
    logic [2:0]  r_keep;
    logic [1:0]  r_ci;
    logic        r_half;
    logic [15:0] r_room;
    logic [15:0] r_wc;
    logic        r_ovld;
    logic [7:0]  r_byte;
    logic        r_ilast;
    logic        r_send;
    logic [15:0] r_bw;

    t_code       w_cur;
    logic        w_wide;
    logic [7:0]  w_byte;
    logic        w_code_done;
    logic        w_later;
    logic [1:0]  w_nxt_ci;
    logic        w_adv;
    logic        w_emit;
    logic        w_emit_last;
    logic        w_load;
    logic [15:0] w_room_after;
    logic [2:0]  w_room_c;
    logic [2:0]  w_len [3];
    logic [2:0]  w_used0;
    logic [2:0]  w_used1;
    logic [2:0]  w_keep;

    always_comb begin
        case (r_ci)
            2'd1:    w_cur = r_ent.codes[1];
            2'd2:    w_cur = r_ent.codes[2];
            default: w_cur = r_ent.codes[0];
        endcase
    end

    always_comb begin
        case (r_ci)
            2'd0: begin
                w_later  = r_keep[1] || r_keep[2];
                w_nxt_ci = r_keep[1] ? 2'd1 : 2'd2;
            end
            2'd1: begin
                w_later  = r_keep[2];
                w_nxt_ci = 2'd2;
            end
            default: begin
                w_later  = 1'b0;
                w_nxt_ci = 2'd2;
            end
        endcase
    end

    assign w_wide      = is_wide(w_cur.gray);
    assign w_byte      = r_half ? w_cur.cnt[7:0]
                       : {w_cur.gray, (w_wide ? w_cur.cnt[11:8] : w_cur.cnt[3:0])};
    assign w_code_done = !w_wide || r_half;
    assign w_adv       = !r_ovld || i_out_ready;
    assign w_emit      = r_busy && w_adv;
    assign w_emit_last = w_code_done && !w_later;
    assign w_load      = !r_busy || (w_emit && w_emit_last);
    assign o_pop       = w_load && i_q_valid;

    // Decide which codes of the next entry fit, against the room left after this beat
    always_comb begin
        w_room_after = w_emit ? r_room - 16'd1 : r_room;
        w_room_c     = (w_room_after > 16'd6) ? 3'd7 : w_room_after[2:0];
        for (int i = 0; i < 3; i++) begin
            w_len[i] = is_wide(i_q_entry.codes[i].gray) ? 3'd2 : 3'd1;
        end
        w_keep[0] = i_q_entry.codes[0].vld && (w_len[0] <= w_room_c);
        w_used0   = w_keep[0] ? w_len[0] : 3'd0;
        w_keep[1] = i_q_entry.codes[1].vld && ((w_used0 + w_len[1]) <= w_room_c);
        w_used1   = w_used0 + (w_keep[1] ? w_len[1] : 3'd0);
        w_keep[2] = i_q_entry.codes[2].vld && ((w_used1 + w_len[2]) <= w_room_c);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent  <= i_q_entry;
            r_keep <= w_keep;
            r_ci   <= w_keep[0] ? 2'd0 : (w_keep[1] ? 2'd1 : 2'd2);
        end else if (w_emit && w_code_done) begin
            r_ci <= w_nxt_ci;
        end
        if (w_adv && w_emit) begin
            r_byte  <= w_byte;
            r_ilast <= w_emit_last;
            r_send  <= w_emit_last && r_ent.last;
            r_bw    <= r_wc + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_half <= 1'b0;
            r_room <= CAP_RESET;
            r_wc   <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= o_pop && (w_keep != '0);
                r_half <= 1'b0;
            end else if (w_emit) begin
                r_half <= !w_code_done;
            end
            if (i_cfg_we) begin
                r_room <= (i_cfg_wdata >= r_wc) ? i_cfg_wdata - r_wc : '0;
            end else if (w_emit) begin
                r_room <= r_room - 16'd1;
            end
            if (w_emit) begin
                r_wc <= r_wc + 16'd1;
            end
            if (w_adv) begin
                r_ovld <= w_emit;
            end
        end
    end

    assign o_out_valid     = r_ovld;
    assign o_code_byte     = r_byte;
    assign o_item_last     = r_ilast;
    assign o_stream_end    = r_send;
    assign o_bytes_written = r_bw;

endmodule

[sv/nibble_rle_encoder_top.sv]
// Run-length encoder for packed 4-bit gray pixels. Each input beat carries two
// gray levels (high nibble first); when the level changes, the finished run
// leaves as code bytes, one per output beat. Levels 0 and 15 take a two-byte
// code with a 12-bit count (at most 4095), the other levels a one-byte code with
// a 4-bit count (at most 15); a run reaching its cap leaves as a full chunk and
// counting restarts at 1. A beat with i_last_byte set flushes the open run, and
// the next beat starts a fresh run. The capacity register (i_cfg_wdata on
// i_cfg_we, reset 65535) bounds the bytes kept: a code that would not fit is
// dropped whole and not counted; write it only while the block is idle. The
// front takes one input beat per cycle while its queue of FIFO_DEPTH entries
// has room. The back emits one code byte per cycle through an output register,
// stalling while i_out_ready is low; beats that finish no run never reach the
// back. Up to six bytes can follow from one beat.
module nibble_rle_encoder_top #(
    parameter int unsigned FifoDepth = nre_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // output beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_code_byte,
    output logic        o_item_last,
    output logic        o_stream_end,
    output logic [15:0] o_bytes_written,
    // capacity register
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import nre_pkg::*;

    logic   w_push;
    t_entry w_push_entry;
    logic   w_q_rdy;
    logic   w_q_vld;
    logic   w_pop;
    t_entry w_q_entry;

    // Front: track the run, turn each beat into its list of finished codes
    nre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_ready   (w_q_rdy),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    // Queue: decouple run tracking from byte output
    nre_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_rdy   (w_q_rdy),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_entry (w_q_entry)
    );

    // Back: apply capacity, expand codes to bytes, mark item and stream ends
    nre_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_valid       (w_q_vld),
        .i_q_entry       (w_q_entry),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_code_byte     (o_code_byte),
        .o_item_last     (o_item_last),
        .o_stream_end    (o_stream_end),
        .o_bytes_written (o_bytes_written)
    );

    // A stream end always closes the bytes of its beat
    a_end_is_item_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_end |-> o_item_last)
        else $error("stream end without item last");

    // The front pushes only into a queue with room
    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_rdy)
        else $error("push into full queue");

    // The back pops only a present entry
    a_pop_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_vld)
        else $error("pop from empty queue");

    // Consecutive output beats count up by one
    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready ##1 o_out_valid |->
            o_bytes_written == $past(o_bytes_written) + 16'd1)
        else $error("byte count skipped");

endmodule
